// ===== rtl/core/csv_structural_indexer_defines.svh =====
// Assertion macros shared by the indexer's checker.
// No dependencies; included by the files that assert.
`ifndef CSV_STRUCTURAL_INDEXER_DEFINES_SVH
`define CSV_STRUCTURAL_INDEXER_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define CSI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define CSI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/csi_pkg.sv =====
// Shared constants and types of the CSV structural indexer.
// No dependencies; imported by every module of the block.
package csi_pkg;

   localparam int DATA_WIDTH        = 64;
   localparam int MAX_LANES         = DATA_WIDTH / 8;
   localparam int COUNT_WIDTH       = 4;
   localparam int CNT_WIDTH         = $clog2(MAX_LANES + 1);
   localparam int POS_WIDTH         = 18;
   localparam int ROW_WIDTH         = 32;
   localparam int COL_WIDTH         = 16;
   localparam int BYTES_PER_ITEM_DEF = 8;
   localparam int BUFFER_BYTES_DEF  = 262144;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] QUOTE_CHAR   = 8'h22;
   localparam logic [7:0] COMMA_CHAR   = 8'h2C;

   localparam logic KIND_COMMA   = 1'b0;
   localparam logic KIND_ROW_END = 1'b1;

   typedef struct packed {
      logic quoted;
      logic newline;
      logic field_end;
      logic row_end;
   } lane_flags_type;

   typedef struct packed {
      logic                 kind;
      logic [POS_WIDTH-1:0] position;
      logic [ROW_WIDTH-1:0] row;
      logic [COL_WIDTH-1:0] column;
   } event_type;

   typedef struct packed {
      logic [MAX_LANES-1:0]      mask;
      event_type [MAX_LANES-1:0] ev;
   } event_set_type;

endpackage

// ===== rtl/core/csi_lane.sv =====
// One byte lane: classifies a text byte and carries the quote state on.
// Depends on csi_pkg.
module csi_lane (
   input  logic                    active,
   input  logic [7:0]              byte_in,
   input  logic                    quoted_in,
   input  logic                    newline_in,
   output csi_pkg::lane_flags_type flags
);
   import csi_pkg::*;

   logic quote_hit;
   logic newline_hit;
   logic comma_hit;

   assign quote_hit   = (byte_in == QUOTE_CHAR);
   assign newline_hit = (byte_in == NEWLINE_CHAR);
   assign comma_hit   = (byte_in == COMMA_CHAR);

   always_comb begin
      flags.quoted    = quoted_in;
      flags.newline   = newline_in;
      flags.field_end = 1'b0;
      flags.row_end   = 1'b0;
      if (active) begin
         if (quote_hit) begin
            flags.quoted = quoted_in ? 1'b0 : newline_in;
         end
         flags.field_end = comma_hit && !quoted_in;
         flags.row_end   = newline_hit && !quoted_in;
         flags.newline   = newline_hit;
      end
   end

endmodule

// ===== rtl/core/csi_merge.sv =====
// Merging stage: turns the lane flags into a set of events and the next counters.
// Depends on csi_pkg.
module csi_merge #(
   parameter int BUFFER_BYTES = csi_pkg::BUFFER_BYTES_DEF,
   parameter int PW           = $clog2(BUFFER_BYTES)
) (
   input  csi_pkg::lane_flags_type [csi_pkg::MAX_LANES-1:0] flags,
   input  logic [PW-1:0]                   position,
   input  logic [csi_pkg::ROW_WIDTH-1:0]   rows,
   input  logic [csi_pkg::COL_WIDTH-1:0]   column,
   input  logic [csi_pkg::COUNT_WIDTH-1:0] count,
   input  logic                            buffer_start,
   input  logic                            emit_columns,
   output csi_pkg::event_set_type          set,
   output logic [PW-1:0]                   position_next,
   output logic [csi_pkg::ROW_WIDTH-1:0]   rows_next,
   output logic [csi_pkg::COL_WIDTH-1:0]   column_next
);
   import csi_pkg::*;

   localparam logic [PW:0] LIMIT = (PW + 1)'(BUFFER_BYTES);

   always_comb begin : merge_proc
      logic [PW-1:0]          base;
      logic [PW:0]            pos_sum;
      logic [PW:0]            pos_wrap;
      logic [PW+POS_WIDTH-1:0] pos_wide;
      logic [CNT_WIDTH-1:0]   nl_cnt;
      logic [CNT_WIDTH-1:0]   field_cnt;
      logic                   col_cleared;
      logic [ROW_WIDTH:0]     row_sum;
      logic [COL_WIDTH:0]     col_sum;

      base        = buffer_start ? '0 : position;
      nl_cnt      = '0;
      field_cnt   = '0;
      col_cleared = 1'b0;
      set         = '0;
      for (int i = 0; i < MAX_LANES; i++) begin
         pos_sum  = {1'b0, base} + (PW + 1)'(i);
         pos_wrap = (pos_sum >= LIMIT) ? pos_sum - LIMIT : pos_sum;
         pos_wide = {{POS_WIDTH{1'b0}}, pos_wrap[PW-1:0]};
         if (flags[i].row_end) begin
            nl_cnt = nl_cnt + CNT_WIDTH'(1);
         end
         row_sum = {1'b0, rows} + (ROW_WIDTH + 1)'(nl_cnt);
         col_sum = {1'b0, column} + (COL_WIDTH + 1)'(field_cnt);
         set.ev[i].kind     = flags[i].row_end ? KIND_ROW_END : KIND_COMMA;
         set.ev[i].position = pos_wide[POS_WIDTH-1:0];
         set.ev[i].row      = row_sum[ROW_WIDTH] ? '1 : row_sum[ROW_WIDTH-1:0];
         if (col_cleared) begin
            set.ev[i].column = COL_WIDTH'(field_cnt);
         end else begin
            set.ev[i].column = col_sum[COL_WIDTH] ? '1 : col_sum[COL_WIDTH-1:0];
         end
         set.mask[i] = flags[i].row_end || (flags[i].field_end && emit_columns);
         if (flags[i].field_end) begin
            field_cnt = field_cnt + CNT_WIDTH'(1);
         end
         if (flags[i].row_end) begin
            field_cnt   = '0;
            col_cleared = 1'b1;
         end
      end

      row_sum = {1'b0, rows} + (ROW_WIDTH + 1)'(nl_cnt);
      col_sum = {1'b0, column} + (COL_WIDTH + 1)'(field_cnt);
      rows_next = row_sum[ROW_WIDTH] ? '1 : row_sum[ROW_WIDTH-1:0];
      if (col_cleared) begin
         column_next = COL_WIDTH'(field_cnt);
      end else begin
         column_next = col_sum[COL_WIDTH] ? '1 : col_sum[COL_WIDTH-1:0];
      end
      pos_sum       = {1'b0, base} + (PW + 1)'(count);
      pos_wrap      = (pos_sum >= LIMIT) ? pos_sum - LIMIT : pos_sum;
      position_next = pos_wrap[PW-1:0];
   end

endmodule

// ===== rtl/core/csi_drain.sv =====
// Two-stage event queue: holds event sets and hands them out one word at a time.
// Depends on csi_pkg.
module csi_drain (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  csi_pkg::event_set_type set_in,
   output logic                   load_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output csi_pkg::event_type     rsp_event,
   output logic                   rsp_last
);
   import csi_pkg::*;

   logic [MAX_LANES-1:0]      a_mask_ff, a_mask_in;
   event_type [MAX_LANES-1:0] a_ev_ff, a_ev_in;
   logic [MAX_LANES-1:0]      b_mask_ff, b_mask_in;
   event_type [MAX_LANES-1:0] b_ev_ff, b_ev_in;
   logic [MAX_LANES-1:0]      sel;
   logic                      fire;
   logic                      b_free;
   logic                      a_move;

   assign sel       = b_mask_ff & (~b_mask_ff + MAX_LANES'(1));
   assign rsp_valid = |b_mask_ff;
   assign rsp_last  = ((b_mask_ff & ~sel) == '0);
   assign fire      = rsp_valid && rsp_ready;
   assign b_free    = !rsp_valid || (fire && rsp_last);
   assign a_move    = (|a_mask_ff) && b_free;
   assign load_ready = !(|a_mask_ff) || a_move;

   always_comb begin
      rsp_event = '0;
      for (int i = 0; i < MAX_LANES; i++) begin
         if (sel[i]) begin
            rsp_event = rsp_event | b_ev_ff[i];
         end
      end
   end

   always_comb begin
      a_mask_in = a_mask_ff;
      a_ev_in   = a_ev_ff;
      if (load) begin
         a_mask_in = set_in.mask;
         a_ev_in   = set_in.ev;
      end else if (a_move) begin
         a_mask_in = '0;
      end
      b_mask_in = b_mask_ff;
      b_ev_in   = b_ev_ff;
      if (a_move) begin
         b_mask_in = a_mask_ff;
         b_ev_in   = a_ev_ff;
      end else if (fire) begin
         b_mask_in = b_mask_ff & ~sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_mask_ff <= '0;
         b_mask_ff <= '0;
      end else begin
         a_mask_ff <= a_mask_in;
         b_mask_ff <= b_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ev_ff <= a_ev_in;
      b_ev_ff <= b_ev_in;
   end

endmodule

// ===== rtl/core/csv_structural_indexer.sv =====
// Top level of the CSV structural indexer: byte lanes, merge and event queue.
// Depends on csi_pkg, csi_lane, csi_merge and csi_drain.
//
// Usage: the req channel carries one word of up to eight text bytes (first
// byte in bits 7:0), a byte count and a buffer start flag. Each comma and
// newline outside a quoted region becomes one rsp word with its kind, byte
// position, row number and column index; the last event of a word carries
// rsp_last_in_item. Comma events are suppressed while the csr register's bit
// is low. The csr channel is always ready; write it only while the block is idle.
// With the queue empty, an accepted word is registered in stage a and then
// moved to stage b; rsp_valid rises once its events are in stage b.
// One req word per cycle while words carry at most one event each and rsp_ready
// stays high; a word with more events holds the rsp port while the rsp port
// drains the event set one word per cycle.
// A second word is taken while the output stalls, then req_ready drops.
// Reset: synchronous; clears quote state, counters and queued events, sets the
// was-newline flag and enables comma events.
module csv_structural_indexer #(
   parameter int BYTES_PER_ITEM = csi_pkg::BYTES_PER_ITEM_DEF,
   parameter int BUFFER_BYTES   = csi_pkg::BUFFER_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [csi_pkg::DATA_WIDTH-1:0]  req_data_word,
   input  logic [csi_pkg::COUNT_WIDTH-1:0] req_byte_count,
   input  logic                            req_buffer_start,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_event_kind,
   output logic [csi_pkg::POS_WIDTH-1:0]   rsp_position,
   output logic [csi_pkg::ROW_WIDTH-1:0]   rsp_row_number,
   output logic [csi_pkg::COL_WIDTH-1:0]   rsp_column_index,
   output logic                            rsp_last_in_item
);
   import csi_pkg::*;

   localparam int LANES = (BYTES_PER_ITEM < MAX_LANES) ? BYTES_PER_ITEM : MAX_LANES;
   localparam int PW    = $clog2(BUFFER_BYTES);

   logic                  emit_columns_ff, emit_columns_in;
   logic                  in_quotes_ff, in_quotes_in;
   logic                  prev_newline_ff, prev_newline_in;
   logic [PW-1:0]         position_ff, position_in;
   logic [ROW_WIDTH-1:0]  rows_ff, rows_in;
   logic [COL_WIDTH-1:0]  column_ff, column_in;

   logic [COUNT_WIDTH-1:0]          count;
   logic                            req_fire;
   lane_flags_type [MAX_LANES-1:0]  flags;
   logic [MAX_LANES:0]              quoted_chain;
   logic [MAX_LANES:0]              newline_chain;
   event_set_type                   set;
   event_type                       rsp_event;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign count     = (req_byte_count > COUNT_WIDTH'(LANES)) ? COUNT_WIDTH'(LANES)
                                                              : req_byte_count;

   assign quoted_chain[0]  = in_quotes_ff;
   assign newline_chain[0] = prev_newline_ff;

   for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
      if (i < LANES) begin : g_on
         csi_lane u_lane (
            .active     (COUNT_WIDTH'(i) < count),
            .byte_in    (req_data_word[8*i +: 8]),
            .quoted_in  (quoted_chain[i]),
            .newline_in (newline_chain[i]),
            .flags      (flags[i])
         );
      end else begin : g_off
         assign flags[i] = '{quoted: quoted_chain[i], newline: newline_chain[i],
                             field_end: 1'b0, row_end: 1'b0};
      end
      assign quoted_chain[i+1]  = flags[i].quoted;
      assign newline_chain[i+1] = flags[i].newline;
   end

   csi_merge #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .PW           (PW)
   ) u_merge (
      .flags         (flags),
      .position      (position_ff),
      .rows          (rows_ff),
      .column        (column_ff),
      .count         (count),
      .buffer_start  (req_buffer_start),
      .emit_columns  (emit_columns_ff),
      .set           (set),
      .position_next (position_in),
      .rows_next     (rows_in),
      .column_next   (column_in)
   );

   assign in_quotes_in    = quoted_chain[MAX_LANES];
   assign prev_newline_in = newline_chain[MAX_LANES];
   assign emit_columns_in = (csr_valid && csr_ready) ? csr_data : emit_columns_ff;

   csi_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (req_fire),
      .set_in     (set),
      .load_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_event  (rsp_event),
      .rsp_last   (rsp_last_in_item)
   );

   assign rsp_event_kind   = rsp_event.kind;
   assign rsp_position     = rsp_event.position;
   assign rsp_row_number   = rsp_event.row;
   assign rsp_column_index = rsp_event.column;

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_columns_ff <= 1'b1;
         in_quotes_ff    <= 1'b0;
         prev_newline_ff <= 1'b1;
         position_ff     <= '0;
         rows_ff         <= '0;
         column_ff       <= '0;
      end else begin
         emit_columns_ff <= emit_columns_in;
         if (req_fire) begin
            in_quotes_ff    <= in_quotes_in;
            prev_newline_ff <= prev_newline_in;
            position_ff     <= position_in;
            rows_ff         <= rows_in;
            column_ff       <= column_in;
         end
      end
   end

endmodule

// ===== rtl/core/csi_checker.sv =====
// Port-level checker for the CSV structural indexer, bound to the top level.
// Depends on csi_pkg and csv_structural_indexer_defines.svh.
`include "csv_structural_indexer_defines.svh"

module csi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_event_kind,
   input logic [csi_pkg::POS_WIDTH-1:0] rsp_position,
   input logic [csi_pkg::ROW_WIDTH-1:0] rsp_row_number,
   input logic [csi_pkg::COL_WIDTH-1:0] rsp_column_index,
   input logic                          rsp_last_in_item
);
   import csi_pkg::*;

   `CSI_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `CSI_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position) && $stable(rsp_row_number) && $stable(rsp_column_index), "rsp word changed while stalled")

   `CSI_ASSERT(a_rows_monotonic, clock, reset,
      rsp_valid && rsp_ready |=> !rsp_valid || (rsp_row_number >= $past(rsp_row_number)), "row number went backwards")

   `CSI_ASSERT(a_row_end_counted, clock, reset,
      rsp_valid && (rsp_event_kind == KIND_ROW_END) |-> rsp_row_number != '0, "row end with zero rows")

   `CSI_ASSERT(a_item_continues, clock, reset,
      rsp_valid && rsp_ready && !rsp_last_in_item |=> rsp_valid, "events of a word interrupted")

endmodule

bind csv_structural_indexer csi_checker u_csi_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_position     (rsp_position),
   .rsp_row_number   (rsp_row_number),
   .rsp_column_index (rsp_column_index),
   .rsp_last_in_item (rsp_last_in_item)
);
